### hw/rtl/rotation_matrix_to_quaternion_unit_defines.svh
// Assertion macros shared by the rotation matrix to quaternion unit.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq: same-cycle check failed");

// Next-cycle implication, checked on clk, off during reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq: next-cycle check failed");

`endif

### hw/rtl/rmq_pkg.sv
// Shared types, constants and width helpers for the quaternion unit.
package rmq_pkg;

  // magnitudes are brought below 2^MAG_LIMIT_BITS before squaring
  localparam int MAG_LIMIT_BITS = 24;
  // extra fraction bits carried by the norm
  localparam int EXTRA_BITS     = 6;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_ROW0  = 2'd1,
    CASE_ROW1  = 2'd2,
    CASE_ROW2  = 2'd3
  } case_t;

  // signed width of one scaled component
  function automatic int comp_width(input int dw, input int fb);
    int m;
    m = (dw + 2 > fb + 1) ? dw + 2 : fb + 1;
    return m + 1;
  endfunction

  // width of a magnitude after the range shift
  function automatic int smag_width(input int dw, input int fb);
    int mw;
    mw = comp_width(dw, fb) - 1;
    return (mw < MAG_LIMIT_BITS) ? mw : MAG_LIMIT_BITS;
  endfunction

  // width of the norm root (sum of squares scaled by 2^(2*EXTRA_BITS))
  function automatic int root_width(input int dw, input int fb);
    return smag_width(dw, fb) + 1 + EXTRA_BITS;
  endfunction

endpackage

### hw/rtl/rmq_if.sv
// Valid/ready channel interfaces: matrix in, quaternion out.
interface rmq_mat_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] r00, r01, r02;
  logic signed [DW-1:0] r10, r11, r12;
  logic signed [DW-1:0] r20, r21, r22;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

interface rmq_quat_if #(parameter int DW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] qw, qx, qy, qz;
  rmq_pkg::case_t       case_taken;

  modport source (output valid, qw, qx, qy, qz, case_taken, input ready);
  modport sink   (input valid, qw, qx, qy, qz, case_taken, output ready);
endinterface

### hw/rtl/rmq_prep.sv
// Front pipeline: case pick, scaled components, range shift, sum of squares.
module rmq_prep #(
  parameter int DW = 16,
  parameter int FB = 14,
  localparam int SMW  = rmq_pkg::smag_width(DW, FB),
  localparam int SUMW = 2 * SMW + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rmq_mat_if.sink               in_m,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUMW-1:0]       out_sum,
  output logic [3:0][SMW-1:0]   out_mag,
  output logic [3:0]            out_neg,
  output rmq_pkg::case_t        out_sel
);

  localparam int CW = rmq_pkg::comp_width(DW, FB);
  localparam int MW = CW - 1;
  localparam logic signed [CW-1:0] ONE = CW'(1) << FB;

  logic [4:0] ld;
  logic [4:0] v_r;

  // stage load enables: a stage moves when empty or when its successor moves
  assign ld[4] = ~v_r[4] | out_ready;
  assign ld[3] = ~v_r[3] | ld[4];
  assign ld[2] = ~v_r[2] | ld[3];
  assign ld[1] = ~v_r[1] | ld[2];
  assign ld[0] = ~v_r[0] | ld[1];
  assign in_m.ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_m.valid;
      if (ld[1]) v_r[1] <= v_r[0];
      if (ld[2]) v_r[2] <= v_r[1];
      if (ld[3]) v_r[3] <= v_r[2];
      if (ld[4]) v_r[4] <= v_r[3];
    end
  end

  // ---- stage 1: case select and scaled components
  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [CW-1:0] tr, arg;
  logic signed [CW-1:0] c_nxt [4];
  logic signed [CW-1:0] c1_r  [4];
  rmq_pkg::case_t       sel_nxt, sel1_r;

  assign e00 = CW'(in_m.r00);
  assign e01 = CW'(in_m.r01);
  assign e02 = CW'(in_m.r02);
  assign e10 = CW'(in_m.r10);
  assign e11 = CW'(in_m.r11);
  assign e12 = CW'(in_m.r12);
  assign e20 = CW'(in_m.r20);
  assign e21 = CW'(in_m.r21);
  assign e22 = CW'(in_m.r22);
  assign tr  = e00 + e11 + e22;

  always_comb begin
    if (tr > 0)                     sel_nxt = rmq_pkg::CASE_TRACE;
    else if (e00 > e11 && e00 > e22) sel_nxt = rmq_pkg::CASE_ROW0;
    else if (e11 > e22)             sel_nxt = rmq_pkg::CASE_ROW1;
    else                            sel_nxt = rmq_pkg::CASE_ROW2;
  end

  always_comb begin
    case (sel_nxt)
      rmq_pkg::CASE_TRACE: arg = ONE + tr;
      rmq_pkg::CASE_ROW0:  arg = ONE + e00 - e11 - e22;
      rmq_pkg::CASE_ROW1:  arg = ONE + e11 - e00 - e22;
      default:             arg = ONE + e22 - e00 - e11;
    endcase
    // floor of one LSB
    if (arg < 1) arg = CW'(1);
    case (sel_nxt)
      rmq_pkg::CASE_TRACE: begin
        c_nxt[0] = arg;       c_nxt[1] = e21 - e12;
        c_nxt[2] = e02 - e20; c_nxt[3] = e10 - e01;
      end
      rmq_pkg::CASE_ROW0: begin
        c_nxt[0] = e21 - e12; c_nxt[1] = arg;
        c_nxt[2] = e01 + e10; c_nxt[3] = e02 + e20;
      end
      rmq_pkg::CASE_ROW1: begin
        c_nxt[0] = e02 - e20; c_nxt[1] = e01 + e10;
        c_nxt[2] = arg;       c_nxt[3] = e12 + e21;
      end
      default: begin
        c_nxt[0] = e10 - e01; c_nxt[1] = e02 + e20;
        c_nxt[2] = e12 + e21; c_nxt[3] = arg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 4; i++) c1_r[i] <= c_nxt[i];
      sel1_r <= sel_nxt;
    end
  end

  // ---- stage 2: magnitudes, signs and largest magnitude
  logic [MW-1:0]  mag_nxt [4];
  logic [MW-1:0]  mx_nxt;
  logic [MW-1:0]  mag2_r  [4];
  logic [MW-1:0]  mx2_r;
  logic [3:0]     neg2_r;
  rmq_pkg::case_t sel2_r;

  always_comb begin
    logic signed [CW-1:0] ab;
    for (int i = 0; i < 4; i++) begin
      ab         = c1_r[i][CW-1] ? -c1_r[i] : c1_r[i];
      mag_nxt[i] = ab[MW-1:0];
    end
    mx_nxt = mag_nxt[0];
    for (int i = 1; i < 4; i++) begin
      if (mag_nxt[i] > mx_nxt) mx_nxt = mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 4; i++) begin
        mag2_r[i] <= mag_nxt[i];
        neg2_r[i] <= c1_r[i][CW-1];
      end
      mx2_r  <= mx_nxt;
      sel2_r <= sel1_r;
    end
  end

  // ---- stage 3: shift all magnitudes until the largest fits the limit
  logic [SMW-1:0] smag_nxt [4];
  logic [SMW-1:0] smag3_r  [4];
  logic [3:0]     neg3_r;
  rmq_pkg::case_t sel3_r;

  if (MW > rmq_pkg::MAG_LIMIT_BITS) begin : g_shift
    localparam int SHW = $clog2(MW);
    logic [SHW-1:0] pos, sh;
    logic [MW-1:0]  tmp [4];
    always_comb begin
      pos = '0;
      for (int b = 0; b < MW; b++) begin
        if (mx2_r[b]) pos = SHW'(b);
      end
      if (pos >= SHW'(rmq_pkg::MAG_LIMIT_BITS))
        sh = pos - SHW'(rmq_pkg::MAG_LIMIT_BITS - 1);
      else
        sh = '0;
      for (int i = 0; i < 4; i++) begin
        tmp[i]      = mag2_r[i] >> sh;
        smag_nxt[i] = tmp[i][SMW-1:0];
      end
    end
  end else begin : g_noshift
    // largest possible magnitude is already below the limit
    always_comb begin
      for (int i = 0; i < 4; i++) smag_nxt[i] = mag2_r[i][SMW-1:0];
    end
    logic unused_mx;
    assign unused_mx = ^mx2_r;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 4; i++) smag3_r[i] <= smag_nxt[i];
      neg3_r <= neg2_r;
      sel3_r <= sel2_r;
    end
  end

  // ---- stage 4: squares
  logic [2*SMW-1:0] sq4_r   [4];
  logic [SMW-1:0]   smag4_r [4];
  logic [3:0]       neg4_r;
  rmq_pkg::case_t   sel4_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < 4; i++) begin
        sq4_r[i]   <= smag3_r[i] * smag3_r[i];
        smag4_r[i] <= smag3_r[i];
      end
      neg4_r <= neg3_r;
      sel4_r <= sel3_r;
    end
  end

  // ---- stage 5: sum of squares
  logic [SUMW-1:0] sum5_r;
  logic [SMW-1:0]  smag5_r [4];
  logic [3:0]      neg5_r;
  rmq_pkg::case_t  sel5_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      sum5_r <= SUMW'(sq4_r[0]) + SUMW'(sq4_r[1]) + SUMW'(sq4_r[2]) + SUMW'(sq4_r[3]);
      for (int i = 0; i < 4; i++) smag5_r[i] <= smag4_r[i];
      neg5_r <= neg4_r;
      sel5_r <= sel4_r;
    end
  end

  assign out_valid = v_r[4];
  assign out_sum   = sum5_r;
  assign out_neg   = neg5_r;
  assign out_sel   = sel5_r;
  always_comb begin
    for (int i = 0; i < 4; i++) out_mag[i] = smag5_r[i];
  end

endmodule

### hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, with side payload.
module rmq_sqrt #(
  parameter int RW  = 25,
  parameter int SDW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*RW-1:0] in_x,
  input  logic [SDW-1:0]  in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [RW-1:0]   out_root,
  output logic [SDW-1:0]  out_side
);

  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] x_r    [RW];
  logic [SDW-1:0]  side_r [RW];
  logic            v_r    [RW];
  logic            ld     [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic [RW+1:0]   p_rem;
    logic [RW-1:0]   p_root;
    logic [2*RW-1:0] p_x;
    logic [SDW-1:0]  p_side;
    logic            p_v;
    logic [RW+1:0]   remsh, trial, rem_nxt;
    logic            take;

    if (k == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_x    = in_x;
      assign p_side = in_side;
      assign p_v    = in_valid;
    end else begin : g_chain
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_x    = x_r[k-1];
      assign p_side = side_r[k-1];
      assign p_v    = v_r[k-1];
    end

    if (k == RW - 1) begin : g_last
      assign ld[k] = ~v_r[k] | out_ready;
    end else begin : g_mid
      assign ld[k] = ~v_r[k] | ld[k+1];
    end

    // bring down two radicand bits, try root*4+1
    assign remsh   = {p_rem[RW-1:0], p_x[2*RW-1 -: 2]};
    assign trial   = {p_root, 2'b01};
    assign take    = (remsh >= trial);
    assign rem_nxt = take ? (remsh - trial) : remsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {p_root[RW-2:0], take};
        x_r[k]    <= p_x << 2;
        side_r[k] <= p_side;
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

### hw/rtl/rmq_div.sv
// Four-lane pipelined restoring divider, rounding, saturation and sign.
module rmq_div #(
  parameter int DW = 16,
  parameter int FB = 14,
  localparam int SMW = rmq_pkg::smag_width(DW, FB),
  localparam int RW  = rmq_pkg::root_width(DW, FB)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [RW-1:0]       in_root,
  input  logic [3:0][SMW-1:0] in_mag,
  input  logic [3:0]          in_neg,
  input  rmq_pkg::case_t      in_sel,
  rmq_quat_if.source          out_q
);

  // quotient never exceeds 2^FB because the norm bounds every magnitude
  localparam int QW  = FB + 1;
  localparam int DVW = RW + QW;
  localparam int NS  = QW + 2;
  localparam int EW  = ((QW > DW) ? QW : DW) + 1;

  logic [3:0][DVW-1:0] rem_r [NS-1];
  logic [3:0][QW-1:0]  q_r   [NS-1];
  logic [RW-1:0]       n_r   [NS-1];
  logic [3:0]          neg_r [NS];
  rmq_pkg::case_t      sel_r [NS];
  logic                v_r   [NS];
  logic                ld    [NS];
  logic [3:0][DW-1:0]  qo_r;

  // load enables
  for (genvar k = 0; k < NS; k++) begin : g_ld
    if (k == NS - 1) begin : g_last
      assign ld[k] = ~v_r[k] | out_q.ready;
    end else begin : g_mid
      assign ld[k] = ~v_r[k] | ld[k+1];
    end
  end

  // valid chain
  for (genvar k = 0; k < NS; k++) begin : g_v
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // ---- setup: dividend = mag*2^(FB+6) + n/2 for round half up
  logic [RW-1:0] n_nxt;
  assign n_nxt = (in_root == '0) ? RW'(1) : in_root;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int l = 0; l < 4; l++) begin
        rem_r[0][l] <= (DVW'(in_mag[l]) << (FB + rmq_pkg::EXTRA_BITS)) + DVW'(n_nxt >> 1);
        q_r[0][l]   <= '0;
      end
      n_r[0]   <= n_nxt;
      neg_r[0] <= in_neg;
      sel_r[0] <= in_sel;
    end
  end

  // ---- quotient stages, most significant bit first
  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [DVW-1:0] dsh;
    assign dsh = DVW'(n_r[k-1]) << (QW - k);

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        for (int l = 0; l < 4; l++) begin
          if (rem_r[k-1][l] >= dsh) begin
            rem_r[k][l] <= rem_r[k-1][l] - dsh;
            q_r[k][l]   <= {q_r[k-1][l][QW-2:0], 1'b1};
          end else begin
            rem_r[k][l] <= rem_r[k-1][l];
            q_r[k][l]   <= {q_r[k-1][l][QW-2:0], 1'b0};
          end
        end
        n_r[k]   <= n_r[k-1];
        neg_r[k] <= neg_r[k-1];
        sel_r[k] <= sel_r[k-1];
      end
    end
  end

  // ---- output register: saturate, apply sign
  logic [3:0][DW-1:0] qo_nxt;
  always_comb begin
    logic [EW-1:0] qe, sv;
    for (int l = 0; l < 4; l++) begin
      qe = EW'(q_r[QW][l]);
      if (qe > EW'({(DW-1){1'b1}})) qe = EW'({(DW-1){1'b1}});
      sv = neg_r[QW][l] ? (EW'(0) - qe) : qe;
      qo_nxt[l] = sv[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      qo_r         <= qo_nxt;
      neg_r[NS-1]  <= neg_r[QW];
      sel_r[NS-1]  <= sel_r[QW];
    end
  end

  assign in_ready         = ld[0];
  assign out_q.valid      = v_r[NS-1];
  assign out_q.qw         = qo_r[0];
  assign out_q.qx         = qo_r[1];
  assign out_q.qy         = qo_r[2];
  assign out_q.qz         = qo_r[3];
  assign out_q.case_taken = sel_r[NS-1];

endmodule

### hw/rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix (Q2.14) to unit quaternion, Shepperd case selection.
//
// Input channel in_mat carries nine signed matrix elements r00..r22; the
// output channel out_quat carries the normalized quaternion qw,qx,qy,qz and
// the case taken (0 trace positive, 1/2/3 largest diagonal). Both are
// valid/ready; a transaction completes when valid and ready are high.
// One matrix can be accepted every cycle while in_mat.ready is high. The
// pipeline has 5 front stages, one square-root stage per norm bit, a setup
// stage, one divider stage per quotient bit and the output register, with
// RW = min(max(DATA_WIDTH+2, FRAC_BITS+1), 24) + 7 and QW = FRAC_BITS + 1.
// Every stage has its own valid bit and loads when empty or when the stage
// after it moves, so a stall at out_quat fills bubbles first and
// in_mat.ready stays high until the whole pipeline is full; nothing is lost
// or repeated. Synchronous reset (rst_n low) empties every stage.
`include "rotation_matrix_to_quaternion_unit_defines.svh"

module rotation_matrix_to_quaternion_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  rmq_mat_if.sink     in_mat,
  rmq_quat_if.source  out_quat
);

  localparam int SMW  = rmq_pkg::smag_width(DATA_WIDTH, FRAC_BITS);
  localparam int SUMW = 2 * SMW + 2;
  localparam int RW   = rmq_pkg::root_width(DATA_WIDTH, FRAC_BITS);
  localparam int SDW  = 2 + 4 + 4 * SMW;
  localparam int PADW = 2 * RW - SUMW;

  // front pipeline -> square root
  logic                pv, pr;
  logic [SUMW-1:0]     psum;
  logic [3:0][SMW-1:0] pmag;
  logic [3:0]          pneg;
  rmq_pkg::case_t      psel;

  rmq_prep #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_m      (in_mat),
    .out_valid (pv),
    .out_ready (pr),
    .out_sum   (psum),
    .out_mag   (pmag),
    .out_neg   (pneg),
    .out_sel   (psel)
  );

  // square root of sum * 2^(2*EXTRA_BITS), side payload rides along
  logic               sq_valid, sq_ready;
  logic [RW-1:0]      sq_root;
  logic [SDW-1:0]     sq_side;
  logic [2*RW-1:0]    sq_x;
  rmq_pkg::case_t     sq_sel;
  logic [3:0]         sq_neg;
  logic [3:0][SMW-1:0] sq_mag;

  assign sq_x = {psum, {PADW{1'b0}}};

  rmq_sqrt #(.RW(RW), .SDW(SDW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pv),
    .in_ready  (pr),
    .in_x      (sq_x),
    .in_side   ({psel, pneg, pmag}),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign sq_sel = rmq_pkg::case_t'(sq_side[SDW-1 -: 2]);
  assign sq_neg = sq_side[4*SMW +: 4];
  assign sq_mag = sq_side[4*SMW-1:0];

  rmq_div #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_valid),
    .in_ready (sq_ready),
    .in_root  (sq_root),
    .in_mag   (sq_mag),
    .in_neg   (sq_neg),
    .in_sel   (sq_sel),
    .out_q    (out_quat)
  );

  // the chosen component is always the positive clamped argument
  `RMQ_ASSERT_IMPL(a_trace_w_pos, out_quat.valid && out_quat.case_taken == rmq_pkg::CASE_TRACE, !out_quat.qw[DATA_WIDTH-1])
  `RMQ_ASSERT_IMPL(a_row0_x_pos, out_quat.valid && out_quat.case_taken == rmq_pkg::CASE_ROW0, !out_quat.qx[DATA_WIDTH-1])
  `RMQ_ASSERT_IMPL(a_row1_y_pos, out_quat.valid && out_quat.case_taken == rmq_pkg::CASE_ROW1, !out_quat.qy[DATA_WIDTH-1])
  `RMQ_ASSERT_IMPL(a_row2_z_pos, out_quat.valid && out_quat.case_taken == rmq_pkg::CASE_ROW2, !out_quat.qz[DATA_WIDTH-1])
  // sum of squares is at least one, so the scaled norm is at least 2^EXTRA_BITS
  `RMQ_ASSERT_IMPL(a_norm_floor, sq_valid, sq_root >= RW'(1 << rmq_pkg::EXTRA_BITS))
  // a stalled root result stays in the last root stage
  `RMQ_ASSERT_NEXT(a_root_held, sq_valid && !sq_ready, sq_valid && $stable(sq_root))

endmodule

### dv/tb_rotation_matrix_to_quaternion_unit.sv
// Self-checking testbench for the rotation matrix to quaternion unit.
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_unit;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int LATENCY = 47;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1230;
  localparam logic signed [DW-1:0] ONE = 16'sd16384;

  typedef logic signed [DW-1:0] elem_t;
  typedef struct packed {
    elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  } matrix_t;
  typedef struct packed {
    elem_t qw, qx, qy, qz;
    rmq_pkg::case_t sel;
  } quat_t;
  typedef struct packed {
    matrix_t m;
    logic    known;
    quat_t   q;
  } row_t;

  logic clk;
  logic rst_n;
  rmq_mat_if  #(.DW(DW)) mat_ch ();
  rmq_quat_if #(.DW(DW)) quat_ch ();

  rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_mat(mat_ch.sink), .out_quat(quat_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quat_t expected_quats[$];
  int    errors;
  int    phase;          // idling pattern: 0 none, 1 sender, 2 receiver, 3 both
  bit    hold_off;       // long receiver stall
  bit    dir_done;       // directed rows all sent
  int    idle_cycles;

  // Report one mismatch and count it
  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Integer square root, bitwise restoring
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Shepperd quaternion of one matrix, normalized in fixed point
  function automatic quat_t shepperd_quat(input matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg;
    longint c[4];
    longint unsigned mag[4];
    longint unsigned mx, sum, n, q;
    int sh;
    rmq_pkg::case_t sel;
    quat_t res;
    a00 = m.r00; a01 = m.r01; a02 = m.r02;
    a10 = m.r10; a11 = m.r11; a12 = m.r12;
    a20 = m.r20; a21 = m.r21; a22 = m.r22;
    tr = a00 + a11 + a22;
    if (tr > 0) sel = rmq_pkg::CASE_TRACE;
    else if (a00 > a11 && a00 > a22) sel = rmq_pkg::CASE_ROW0;
    else if (a11 > a22) sel = rmq_pkg::CASE_ROW1;
    else sel = rmq_pkg::CASE_ROW2;
    case (sel)
      rmq_pkg::CASE_TRACE: begin
        arg = 16384 + tr;
        if (arg < 1) arg = 1;
        c[0] = arg; c[1] = a21 - a12; c[2] = a02 - a20; c[3] = a10 - a01;
      end
      rmq_pkg::CASE_ROW0: begin
        arg = 16384 + a00 - a11 - a22;
        if (arg < 1) arg = 1;
        c[0] = a21 - a12; c[1] = arg; c[2] = a01 + a10; c[3] = a02 + a20;
      end
      rmq_pkg::CASE_ROW1: begin
        arg = 16384 + a11 - a00 - a22;
        if (arg < 1) arg = 1;
        c[0] = a02 - a20; c[1] = a01 + a10; c[2] = arg; c[3] = a12 + a21;
      end
      default: begin
        arg = 16384 + a22 - a00 - a11;
        if (arg < 1) arg = 1;
        c[0] = a10 - a01; c[1] = a02 + a20; c[2] = a12 + a21; c[3] = arg;
      end
    endcase
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > mx) mx = mag[i];
    end
    sh = 0;
    while (sh < 63 && (mx >> sh) >= (64'd1 << rmq_pkg::MAG_LIMIT_BITS)) sh++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    n = int_sqrt(sum << (2 * rmq_pkg::EXTRA_BITS));
    if (n == 0) n = 1;
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << (FB + rmq_pkg::EXTRA_BITS)) + (n >> 1)) / n;
      if (q > 32767) q = 32767;
      if (c[i] < 0) q = -q;
      case (i)
        0: res.qw = q[DW-1:0];
        1: res.qx = q[DW-1:0];
        2: res.qy = q[DW-1:0];
        default: res.qz = q[DW-1:0];
      endcase
    end
    res.sel = sel;
    return res;
  endfunction

  function automatic matrix_t diag_matrix(input elem_t d0, input elem_t d1,
                                          input elem_t d2, input elem_t off);
    matrix_t m;
    m = '{default: off};
    m.r00 = d0; m.r11 = d1; m.r22 = d2;
    return m;
  endfunction

  // Random matrix: half near-rotations with small off-diagonals, half wider
  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      elem_t v;
      if (kind < 3) v = $urandom;
      else if (kind < 5) v = $urandom_range(0, 32768) - 16384;
      else v = $urandom_range(0, 8192) - 4096;
      m[i*DW +: DW] = v;
    end
    if (kind >= 5) begin
      // strong diagonal pick drives one particular case
      case ($urandom_range(0, 3))
        0: begin m.r00 = 16000; m.r11 = 15000; m.r22 = 14000; end
        1: begin m.r00 = 8000; m.r11 = -6000; m.r22 = -7000; end
        2: begin m.r00 = -6000; m.r11 = 9000; m.r22 = -7000; end
        default: begin m.r00 = -9000; m.r11 = -6000; m.r22 = 12000; end
      endcase
    end
    return m;
  endfunction

  // Directed table, expected values given only where obvious
  row_t dir_rows[$];
  task automatic build_table();
    row_t r;
    r.known = 1'b1;
    r.m = diag_matrix(ONE, ONE, ONE, 16'sd0);
    r.q = '{qw: ONE, qx: 0, qy: 0, qz: 0, sel: rmq_pkg::CASE_TRACE};
    dir_rows.push_back(r);
    // 180 degrees about x: r00 largest
    r.m = diag_matrix(ONE, -ONE, -ONE, 16'sd0);
    r.q = '{qw: 0, qx: ONE, qy: 0, qz: 0, sel: rmq_pkg::CASE_ROW0};
    dir_rows.push_back(r);
    r.m = diag_matrix(-ONE, ONE, -ONE, 16'sd0);
    r.q = '{qw: 0, qx: 0, qy: ONE, qz: 0, sel: rmq_pkg::CASE_ROW1};
    dir_rows.push_back(r);
    r.m = diag_matrix(-ONE, -ONE, ONE, 16'sd0);
    r.q = '{qw: 0, qx: 0, qy: 0, qz: ONE, sel: rmq_pkg::CASE_ROW2};
    dir_rows.push_back(r);
    // zero matrix: trace zero and all ties fall to the last case
    r.m = '{default: 16'sd0};
    r.q = '{qw: 0, qx: 0, qy: 0, qz: ONE, sel: rmq_pkg::CASE_ROW2};
    dir_rows.push_back(r);
    r.known = 1'b0;
    // ties between two diagonals
    dir_rows.push_back('{m: diag_matrix(-100, -100, -300, 16'sd5), known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(-100, -300, -100, 16'sd7), known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(-300, -100, -100, -16'sd7), known: 0, q: '0});
    // most negative diagonal entries
    dir_rows.push_back('{m: diag_matrix(-32768, -32768, -32768, 16'sd0), known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(-32768, -32768, -32768, 16'sd3), known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(-32768, 32767, 32767, -16'sd32768), known: 0, q: '0});
    // extremes, small values and alternating bit patterns
    dir_rows.push_back('{m: '{default: 16'sh7fff}, known: 0, q: '0});
    dir_rows.push_back('{m: '{default: 16'sh8000}, known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(32767, 32767, 32767, -16'sd32768), known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(-32768, 0, -32768, 16'sd32767), known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(0, 0, 1, -16'sd1), known: 0, q: '0});
    dir_rows.push_back('{m: '{default: 16'shffff}, known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(16'sd0, 16'sd0, 16'sd0, 16'sh5555), known: 0, q: '0});
    dir_rows.push_back('{m: diag_matrix(16'sd0, 16'sd0, 16'sd0, 16'shaaaa), known: 0, q: '0});
  endtask

  // Offer one matrix and wait for its transaction; valid stays high after
  // the transaction so the next call can follow back to back
  task automatic send_matrix(input matrix_t m, input logic known, input quat_t q);
    int idle_pct;
    idle_pct = (phase == 1) ? 82 : ((phase == 3) ? 9 : 0);
    while ($urandom_range(0, 99) < idle_pct) begin
      mat_ch.valid <= 1'b0;
      @(negedge clk);
    end
    mat_ch.valid <= 1'b1;
    {mat_ch.r00, mat_ch.r01, mat_ch.r02, mat_ch.r10, mat_ch.r11, mat_ch.r12,
     mat_ch.r20, mat_ch.r21, mat_ch.r22} <= m;
    do @(posedge clk); while (!mat_ch.ready);
    expected_quats.push_back(known ? q : shepperd_quat(m));
    @(negedge clk);
  endtask

  // Receiver ready pattern, changed at the falling edge
  always @(negedge clk) begin
    if (!rst_n || hold_off) quat_ch.ready <= 1'b0;
    else if (phase == 2) quat_ch.ready <= ($urandom_range(0, 99) >= 82);
    else if (phase == 3) quat_ch.ready <= ($urandom_range(0, 99) >= 9);
    else quat_ch.ready <= 1'b1;
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && quat_ch.valid && quat_ch.ready) begin
      if (expected_quats.size() == 0) begin
        $display("unexpected result transaction");
        errors++;
      end else begin
        quat_t e;
        e = expected_quats.pop_front();
        if (quat_ch.qw !== e.qw) report_mismatch("qw", quat_ch.qw, e.qw);
        if (quat_ch.qx !== e.qx) report_mismatch("qx", quat_ch.qx, e.qx);
        if (quat_ch.qy !== e.qy) report_mismatch("qy", quat_ch.qy, e.qy);
        if (quat_ch.qz !== e.qz) report_mismatch("qz", quat_ch.qz, e.qz);
        if (quat_ch.case_taken !== e.sel)
          report_mismatch("case_taken", quat_ch.case_taken, e.sel);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((mat_ch.valid && mat_ch.ready) || (quat_ch.valid && quat_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL rotation_matrix_to_quaternion_unit");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering without gaps
  initial begin
    hold_off = 1'b0;
    wait (dir_done);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (3 * LATENCY) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    phase = 0;
    idle_cycles = 0;
    dir_done = 1'b0;
    mat_ch.valid = 1'b0;
    {mat_ch.r00, mat_ch.r01, mat_ch.r02, mat_ch.r10, mat_ch.r11, mat_ch.r12,
     mat_ch.r20, mat_ch.r21, mat_ch.r22} = '0;
    quat_ch.ready = 1'b0;
    build_table();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_matrix(dir_rows[i].m, dir_rows[i].known, dir_rows[i].q);
    dir_done = 1'b1;

    for (int i = 0; i < N_RANDOM; i++) begin
      phase = (i * 4) / N_RANDOM;
      if ($urandom_range(0, 19) == 0) phase = 0;  // short stretches without idling
      send_matrix(random_matrix(), 1'b0, '0);
    end
    mat_ch.valid <= 1'b0;
    phase = 0;

    while (expected_quats.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) $display("PASS rotation_matrix_to_quaternion_unit");
    else $display("FAIL rotation_matrix_to_quaternion_unit");
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_if.sv
hw/rtl/rmq_prep.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion_unit.sv
dv/tb_rotation_matrix_to_quaternion_unit.sv
